// ----- rtl/core/assert_macros.svh -----
// assertion macros shared by the hash table rtl
// expects i_clk and i_rst_n in the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds on every edge out of reset
`define SHKH_ASSERT(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define SHKH_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/core/shkh_pkg.sv -----
// shared types, constants and the hash step for the string key hash table
// no dependencies
package shkh_pkg;

    localparam int TABLE_DEPTH   = 256;
    localparam int MAX_KEY_BYTES = 32;
    localparam int SLOT_W        = $clog2(TABLE_DEPTH);
    localparam int N_W           = SLOT_W + 1;
    localparam int KIDX_W        = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam int KSTRIDE       = 2 ** KIDX_W;
    localparam int CNT_W         = $clog2(MAX_KEY_BYTES + 1);
    localparam int QDEPTH        = 2;
    localparam int QPTR_W        = 1;
    localparam int KBUF_AW       = QPTR_W + KIDX_W;
    localparam int KEY_AW        = SLOT_W + KIDX_W;
    localparam int CFG_W         = 9;
    localparam int HASH_W        = 32;
    localparam int VAL_W         = 16;
    localparam int ST_W          = 3;
    localparam int DIV_CNT_W     = $clog2(HASH_W);

    localparam logic [HASH_W-1:0] HASH_SEED = 32'd1315423911;
    localparam logic [CFG_W-1:0]  CFG_RESET = 9'd256;

    localparam logic ACT_ADD = 1'b0;
    localparam logic ACT_GET = 1'b1;

    localparam logic [ST_W-1:0] ST_STORED   = 3'd0;
    localparam logic [ST_W-1:0] ST_FOUND    = 3'd1;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd2;
    localparam logic [ST_W-1:0] ST_NOSPACE  = 3'd3;
    localparam logic [ST_W-1:0] ST_TOOLONG  = 3'd4;

    typedef struct packed {
        logic             action;
        logic [7:0]       key_byte;
        logic             key_last;
        logic [VAL_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [VAL_W-1:0] value_out;
    } t_out_item;

    // one finished key waiting for the probe engine
    typedef struct packed {
        logic              action;
        logic              overflow;
        logic [CNT_W-1:0]  len;
        logic [VAL_W-1:0]  value;
        logic [HASH_W-1:0] hash;
    } t_op;

    typedef struct packed {
        logic               we;
        logic [KBUF_AW-1:0] addr;
        logic [7:0]         data;
    } t_kbuf_wr;

    typedef struct packed {
        logic [CNT_W-1:0] len;
        logic [VAL_W-1:0] value;
    } t_meta;

    localparam int META_W = $bits(t_meta);

    function automatic logic [HASH_W-1:0] hash_step(input logic [HASH_W-1:0] h,
                                                   input logic [7:0] b);
        return h ^ ((h << 5) + {24'd0, b} + (h >> 2));
    endfunction

endpackage

// ----- rtl/core/shkh_ram.sv -----
// generic single write port ram with registered read
// no dependencies
module shkh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                         i_clk,
    input  logic                                         i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                             i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                             o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/shkh_front.sv -----
// byte intake: hashes key bytes, buffers them, emits one op per key
// depends on shkh_pkg
module shkh_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  shkh_pkg::t_in_item        i_in,
    output logic                      o_in_stall,
    input  logic                      i_full,
    input  logic [shkh_pkg::QPTR_W-1:0] i_wbank,
    output shkh_pkg::t_kbuf_wr        o_kbuf_wr,
    output logic                      o_push,
    output shkh_pkg::t_op             o_op
);

    logic [shkh_pkg::HASH_W-1:0] r_hash, n_hash;
    logic [shkh_pkg::CNT_W-1:0]  r_cnt, n_cnt;
    logic                        r_ovf, n_ovf;
    logic                        accept;
    logic                        room;

    always_comb begin
        accept         = i_in_valid && !i_full;
        room           = r_cnt < shkh_pkg::CNT_W'(shkh_pkg::MAX_KEY_BYTES);
        n_hash         = r_hash;
        n_cnt          = r_cnt;
        n_ovf          = r_ovf;
        o_kbuf_wr.we   = 1'b0;
        o_kbuf_wr.addr = {i_wbank, r_cnt[shkh_pkg::KIDX_W-1:0]};
        o_kbuf_wr.data = i_in.key_byte;
        o_push         = 1'b0;
        if (accept) begin
            if (room) begin
                o_kbuf_wr.we = 1'b1;
                n_cnt        = r_cnt + 1'b1;
                n_hash       = shkh_pkg::hash_step(r_hash, i_in.key_byte);
            end else begin
                n_ovf = 1'b1;
            end
        end
        o_op.action   = i_in.action;
        o_op.overflow = n_ovf;
        o_op.len      = n_cnt;
        o_op.value    = i_in.value;
        o_op.hash     = n_hash;
        if (accept && i_in.key_last) begin
            o_push = 1'b1;
            n_hash = shkh_pkg::HASH_SEED;
            n_cnt  = '0;
            n_ovf  = 1'b0;
        end
    end

    assign o_in_stall = i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= shkh_pkg::HASH_SEED;
            r_cnt  <= '0;
            r_ovf  <= 1'b0;
        end else begin
            r_hash <= n_hash;
            r_cnt  <= n_cnt;
            r_ovf  <= n_ovf;
        end
    end

endmodule

// ----- rtl/core/shkh_queue.sv -----
// two entry op queue between intake and probe engine, entry index is the key buffer bank
// depends on shkh_pkg
module shkh_queue (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  shkh_pkg::t_op               i_op,
    input  logic                        i_pop,
    output shkh_pkg::t_op               o_head,
    output logic                        o_full,
    output logic                        o_empty,
    output logic [shkh_pkg::QPTR_W-1:0] o_wbank,
    output logic [shkh_pkg::QPTR_W-1:0] o_rbank
);

    shkh_pkg::t_op               r_ent [shkh_pkg::QDEPTH];
    logic [shkh_pkg::QPTR_W-1:0] r_wp;
    logic [shkh_pkg::QPTR_W-1:0] r_rp;
    logic [shkh_pkg::QPTR_W:0]   r_cnt;

    assign o_full  = r_cnt == (shkh_pkg::QPTR_W + 1)'(shkh_pkg::QDEPTH);
    assign o_empty = r_cnt == '0;
    assign o_head  = r_ent[r_rp];
    assign o_wbank = r_wp;
    assign o_rbank = r_rp;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wp] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/core/shkh_back.sv -----
// probe engine: hash modulo size, quadratic probe, compare, insert, result register
// depends on shkh_pkg, shkh_ram, assert_macros.svh
`include "assert_macros.svh"
module shkh_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [shkh_pkg::CFG_W-1:0]  i_table_size,
    input  shkh_pkg::t_op               i_head,
    input  logic                        i_empty,
    input  logic [shkh_pkg::QPTR_W-1:0] i_rbank,
    output logic                        o_pop,
    output logic [shkh_pkg::KBUF_AW-1:0] o_kbuf_raddr,
    input  logic [7:0]                  i_kbuf_rdata,
    output logic                        o_out_valid,
    output shkh_pkg::t_out_item         o_out,
    input  logic                        i_out_stall
);

    localparam int SLOT_W = shkh_pkg::SLOT_W;
    localparam int N_W    = shkh_pkg::N_W;
    localparam int KIDX_W = shkh_pkg::KIDX_W;
    localparam int CNT_W  = shkh_pkg::CNT_W;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DIV   = 4'd1;
    localparam logic [3:0] S_PROBE = 4'd2;
    localparam logic [3:0] S_MCHK  = 4'd3;
    localparam logic [3:0] S_CRD   = 4'd4;
    localparam logic [3:0] S_CCK   = 4'd5;
    localparam logic [3:0] S_NEXT  = 4'd6;
    localparam logic [3:0] S_CPRD  = 4'd7;
    localparam logic [3:0] S_CPWR  = 4'd8;
    localparam logic [3:0] S_RESP  = 4'd9;

    logic [3:0]                         r_state, n_state;
    logic [shkh_pkg::HASH_W-1:0]        r_hsh, n_hsh;
    logic [N_W-1:0]                     r_rem, n_rem;
    logic [shkh_pkg::DIV_CNT_W-1:0]     r_dcnt, n_dcnt;
    logic [SLOT_W-1:0]                  r_start, n_start;
    logic [SLOT_W-1:0]                  r_h, n_h;
    logic [SLOT_W-1:0]                  r_o, n_o;
    logic [SLOT_W-1:0]                  r_d, n_d;
    logic [CNT_W-1:0]                   r_j, n_j;
    logic [shkh_pkg::ST_W-1:0]          r_status, n_status;
    logic [shkh_pkg::VAL_W-1:0]         r_vout, n_vout;
    logic [shkh_pkg::TABLE_DEPTH-1:0]   r_used, n_used;
    logic                               r_out_valid;
    shkh_pkg::t_out_item                r_out;

    logic [N_W-1:0]   n_eff;
    logic [N_W:0]     div_sh;
    logic [N_W:0]     o_sum, d_sum, h_sum;
    logic [SLOT_W-1:0] o_new, h_new;
    logic [CNT_W-1:0] j_inc;
    logic             load_out;

    logic                      key_we;
    logic [shkh_pkg::KEY_AW-1:0] key_waddr, key_raddr;
    logic [7:0]                key_rdata;
    logic                      meta_we;
    shkh_pkg::t_meta           meta_wdata, meta_rdata;

    shkh_ram #(.WIDTH(8), .DEPTH(shkh_pkg::TABLE_DEPTH * shkh_pkg::KSTRIDE)) u_key_store (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (key_waddr),
        .i_wdata (i_kbuf_rdata),
        .i_raddr (key_raddr),
        .o_rdata (key_rdata)
    );

    shkh_ram #(.WIDTH(shkh_pkg::META_W), .DEPTH(shkh_pkg::TABLE_DEPTH)) u_meta_store (
        .i_clk   (i_clk),
        .i_we    (meta_we),
        .i_waddr (r_h),
        .i_wdata (meta_wdata),
        .i_raddr (r_h),
        .o_rdata (meta_rdata)
    );

    assign key_waddr    = {r_h, r_j[KIDX_W-1:0]};
    assign key_raddr    = {r_h, r_j[KIDX_W-1:0]};
    assign o_kbuf_raddr = {i_rbank, r_j[KIDX_W-1:0]};
    assign meta_wdata   = '{len: i_head.len, value: i_head.value};

    always_comb begin
        if (i_table_size == '0) begin
            n_eff = N_W'(1);
        end else if (32'(i_table_size) > 32'(shkh_pkg::TABLE_DEPTH)) begin
            n_eff = N_W'(shkh_pkg::TABLE_DEPTH);
        end else begin
            n_eff = N_W'(i_table_size);
        end
    end

    always_comb begin
        div_sh = {r_rem, r_hsh[shkh_pkg::HASH_W-1]};
        if (div_sh >= {1'b0, n_eff}) begin
            div_sh = div_sh - {1'b0, n_eff};
        end
        o_sum = (N_W + 1)'(r_o) + (N_W + 1)'(r_d);
        if (o_sum >= {1'b0, n_eff}) begin
            o_sum = o_sum - {1'b0, n_eff};
        end
        o_new = o_sum[SLOT_W-1:0];
        d_sum = (N_W + 1)'(r_d) + (N_W + 1)'(2);
        if (d_sum >= {1'b0, n_eff}) begin
            d_sum = d_sum - {1'b0, n_eff};
        end
        if (d_sum >= {1'b0, n_eff}) begin
            d_sum = d_sum - {1'b0, n_eff};
        end
        h_sum = (N_W + 1)'(r_start) + (N_W + 1)'(o_new);
        if (h_sum >= {1'b0, n_eff}) begin
            h_sum = h_sum - {1'b0, n_eff};
        end
        h_new = h_sum[SLOT_W-1:0];
        j_inc = r_j + 1'b1;
    end

    always_comb begin
        n_state  = r_state;
        n_hsh    = r_hsh;
        n_rem    = r_rem;
        n_dcnt   = r_dcnt;
        n_start  = r_start;
        n_h      = r_h;
        n_o      = r_o;
        n_d      = r_d;
        n_j      = r_j;
        n_status = r_status;
        n_vout   = r_vout;
        n_used   = r_used;
        key_we   = 1'b0;
        meta_we  = 1'b0;
        load_out = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    n_vout = '0;
                    if (i_head.overflow) begin
                        n_status = shkh_pkg::ST_TOOLONG;
                        n_state  = S_RESP;
                    end else begin
                        n_hsh   = i_head.hash;
                        n_rem   = '0;
                        n_dcnt  = '1;
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                n_rem  = div_sh[N_W-1:0];
                n_hsh  = r_hsh << 1;
                n_dcnt = r_dcnt - 1'b1;
                if (r_dcnt == '0) begin
                    n_start = div_sh[SLOT_W-1:0];
                    n_h     = div_sh[SLOT_W-1:0];
                    n_o     = '0;
                    n_d     = (n_eff == N_W'(1)) ? '0 : SLOT_W'(1);
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                n_j = '0;
                if (!r_used[r_h]) begin
                    if (i_head.action == shkh_pkg::ACT_ADD) begin
                        n_state = S_CPRD;
                    end else begin
                        n_status = shkh_pkg::ST_NOTFOUND;
                        n_state  = S_RESP;
                    end
                end else begin
                    n_state = S_MCHK;
                end
            end
            S_MCHK: begin
                n_state = (meta_rdata.len == i_head.len) ? S_CRD : S_NEXT;
            end
            S_CRD: begin
                n_state = S_CCK;
            end
            S_CCK: begin
                if (key_rdata != i_kbuf_rdata) begin
                    n_state = S_NEXT;
                end else if (j_inc != i_head.len) begin
                    n_j     = j_inc;
                    n_state = S_CRD;
                end else if (i_head.action == shkh_pkg::ACT_ADD) begin
                    meta_we  = 1'b1;
                    n_status = shkh_pkg::ST_STORED;
                    n_state  = S_RESP;
                end else begin
                    n_status = shkh_pkg::ST_FOUND;
                    n_vout   = meta_rdata.value;
                    n_state  = S_RESP;
                end
            end
            S_NEXT: begin
                n_o = o_new;
                n_d = d_sum[SLOT_W-1:0];
                n_h = h_new;
                if (h_new == r_start) begin
                    n_status = (i_head.action == shkh_pkg::ACT_ADD) ?
                               shkh_pkg::ST_NOSPACE : shkh_pkg::ST_NOTFOUND;
                    n_state  = S_RESP;
                end else begin
                    n_state = S_PROBE;
                end
            end
            S_CPRD: begin
                n_state = S_CPWR;
            end
            S_CPWR: begin
                key_we = 1'b1;
                if (j_inc == i_head.len) begin
                    meta_we       = 1'b1;
                    n_used[r_h]   = 1'b1;
                    n_status      = shkh_pkg::ST_STORED;
                    n_state       = S_RESP;
                end else begin
                    n_j     = j_inc;
                    n_state = S_CPRD;
                end
            end
            S_RESP: begin
                if (!r_out_valid || !i_out_stall) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_pop       = load_out;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        r_hsh    <= n_hsh;
        r_rem    <= n_rem;
        r_dcnt   <= n_dcnt;
        r_start  <= n_start;
        r_h      <= n_h;
        r_o      <= n_o;
        r_d      <= n_d;
        r_j      <= n_j;
        r_status <= n_status;
        r_vout   <= n_vout;
        if (load_out) begin
            r_out <= '{status: r_status, value_out: r_vout};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    `SHKH_ASSERT_IMP(a_pop_has_entry, o_pop, !i_empty)
    `SHKH_ASSERT_IMP(a_probe_in_range, r_state == S_PROBE,
                     (N_W)'(r_h) < n_eff && (N_W)'(r_start) < n_eff)
    `SHKH_ASSERT_IMP(a_copy_within_key, key_we, r_j < i_head.len && !i_head.overflow)

endmodule

// ----- rtl/core/string_key_hash_table_unit.sv -----
// string key hash table, top level: config register, intake, op queue, probe engine
// depends on shkh_pkg, shkh_ram, shkh_front, shkh_queue, shkh_back
//
// usage:
//   input channel (i_in_valid, i_in, o_in_stall) carries one key byte per
//   transaction; the transaction with key_last set ends the key and carries the
//   action and the value. each key gives exactly one result on the output
//   channel (o_out_valid, o_out, i_out_stall); other bytes give none.
//   config channel (i_cfg_valid, i_cfg_data, o_cfg_ready) writes table_size;
//   it is always ready and must only be written while the block is idle.
// flow:
//   a key byte is taken in the cycle it is offered unless o_in_stall is high;
//   a finished key is queued (two deep). the probe engine forms hash mod size
//   serially (one quotient bit a cycle), visits probed slots (probe, length
//   check, next), reads and checks each byte on a length match, copies each
//   byte on insert and loads the result register once it is free. remainder
//   and probe walk set the rate; a new key can stream in while one is probed.
// reset: used marks, queue, hash state and the result valid flag clear at once;
//   table_size returns to 256. no clearing pass.
// stall: a held result keeps its value; the engine waits, the queue fills,
//   and o_in_stall rises once two keys are pending.
module string_key_hash_table_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  shkh_pkg::t_in_item               i_in,
    output logic                             o_in_stall,
    output logic                             o_out_valid,
    output shkh_pkg::t_out_item              o_out,
    input  logic                             i_out_stall,
    input  logic                             i_cfg_valid,
    input  logic [shkh_pkg::CFG_W-1:0]       i_cfg_data,
    output logic                             o_cfg_ready
);

    // table size register
    logic [shkh_pkg::CFG_W-1:0] r_table_size;

    // intake to queue
    shkh_pkg::t_kbuf_wr          kbuf_wr;
    logic                        push;
    shkh_pkg::t_op               push_op;

    // queue to engine
    shkh_pkg::t_op               head;
    logic                        full;
    logic                        empty;
    logic                        pop;
    logic [shkh_pkg::QPTR_W-1:0] wbank;
    logic [shkh_pkg::QPTR_W-1:0] rbank;

    // key byte buffer, one bank per queue entry
    logic [shkh_pkg::KBUF_AW-1:0] kbuf_raddr;
    logic [7:0]                   kbuf_rdata;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= shkh_pkg::CFG_RESET;
        end else if (i_cfg_valid) begin
            r_table_size <= i_cfg_data;
        end
    end

    shkh_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in       (i_in),
        .o_in_stall (o_in_stall),
        .i_full     (full),
        .i_wbank    (wbank),
        .o_kbuf_wr  (kbuf_wr),
        .o_push     (push),
        .o_op       (push_op)
    );

    // bank is freed only when the engine pops its op
    shkh_ram #(.WIDTH(8), .DEPTH(shkh_pkg::QDEPTH * shkh_pkg::KSTRIDE)) u_kbuf (
        .i_clk   (i_clk),
        .i_we    (kbuf_wr.we),
        .i_waddr (kbuf_wr.addr),
        .i_wdata (kbuf_wr.data),
        .i_raddr (kbuf_raddr),
        .o_rdata (kbuf_rdata)
    );

    shkh_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (push_op),
        .i_pop   (pop),
        .o_head  (head),
        .o_full  (full),
        .o_empty (empty),
        .o_wbank (wbank),
        .o_rbank (rbank)
    );

    shkh_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_table_size (r_table_size),
        .i_head       (head),
        .i_empty      (empty),
        .i_rbank      (rbank),
        .o_pop        (pop),
        .o_kbuf_raddr (kbuf_raddr),
        .i_kbuf_rdata (kbuf_rdata),
        .o_out_valid  (o_out_valid),
        .o_out        (o_out),
        .i_out_stall  (i_out_stall)
    );

endmodule

// ----- verif/tb_string_key_hash_table_unit.sv -----
// testbench for string_key_hash_table_unit: streams keys, predicts every result, scoreboards
// depends on shkh_pkg and the rtl of string_key_hash_table_unit
module tb_string_key_hash_table_unit;
    timeunit 1ns;
    timeprecision 1ps;

    // clock, reset and block ports
    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_in_valid = 1'b0;
    shkh_pkg::t_in_item            i_in = '0;
    logic                          o_in_stall;
    logic                          o_out_valid;
    shkh_pkg::t_out_item           o_out;
    logic                          i_out_stall = 1'b0;
    logic                          i_cfg_valid = 1'b0;
    logic [shkh_pkg::CFG_W-1:0]    i_cfg_data = '0;
    logic                          o_cfg_ready;

    always #5 i_clk = ~i_clk;

    string_key_hash_table_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in        (i_in),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_out_stall (i_out_stall),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready)
    );

    // shadow copy of the table kept by the predictor
    logic [shkh_pkg::CFG_W-1:0]  size_reg = shkh_pkg::CFG_RESET;
    logic                        used_mark [shkh_pkg::TABLE_DEPTH];
    logic [7:0]                  stored_key [shkh_pkg::TABLE_DEPTH][shkh_pkg::MAX_KEY_BYTES];
    int unsigned                 stored_len [shkh_pkg::TABLE_DEPTH];
    logic [shkh_pkg::VAL_W-1:0]  stored_val [shkh_pkg::TABLE_DEPTH];
    logic [shkh_pkg::HASH_W-1:0] run_hash = shkh_pkg::HASH_SEED;
    logic [7:0]                  pending_key [shkh_pkg::MAX_KEY_BYTES];
    int unsigned                 pending_len = 0;
    logic                        pending_long = 1'b0;

    shkh_pkg::t_out_item         expected_results [$];
    int                          mismatches = 0;
    int                          byte_cnt = 0;
    int                          status_cnt [5] = '{0, 0, 0, 0, 0};

    // idle control for both sides; calm mode gives stretches without gaps
    bit                          calm = 1'b0;

    // walk the probe sequence for the finished key and update the shadow table
    function automatic shkh_pkg::t_out_item lookup_or_store(logic act,
                                                            logic [shkh_pkg::VAL_W-1:0] val);
        shkh_pkg::t_out_item res;
        int unsigned n;
        int unsigned start;
        int unsigned slot;
        int unsigned step;
        bit          done;
        bit          same;
        res = '0;
        if (pending_long) begin
            res.status = shkh_pkg::ST_TOOLONG;
            return res;
        end
        n = size_reg;
        if (n < 1) n = 1;
        if (n > shkh_pkg::TABLE_DEPTH) n = shkh_pkg::TABLE_DEPTH;
        start = run_hash % n;
        slot = start;
        step = 1;
        done = 1'b0;
        res.status = (act == shkh_pkg::ACT_ADD) ? shkh_pkg::ST_NOSPACE : shkh_pkg::ST_NOTFOUND;
        while (used_mark[slot]) begin
            same = (stored_len[slot] == pending_len);
            for (int b = 0; b < pending_len && same; b++)
                if (stored_key[slot][b] != pending_key[b]) same = 1'b0;
            if (same) begin
                if (act == shkh_pkg::ACT_ADD) begin
                    stored_val[slot] = val;
                    res.status = shkh_pkg::ST_STORED;
                end else begin
                    res.status = shkh_pkg::ST_FOUND;
                    res.value_out = stored_val[slot];
                end
                done = 1'b1;
                break;
            end
            slot = (start + step * step) % n;
            step++;
            if (slot == start) begin
                done = 1'b1;
                break;
            end
        end
        if (!done && act == shkh_pkg::ACT_ADD) begin
            for (int b = 0; b < pending_len; b++) stored_key[slot][b] = pending_key[b];
            stored_len[slot] = pending_len;
            used_mark[slot] = 1'b1;
            stored_val[slot] = val;
            res.status = shkh_pkg::ST_STORED;
        end
        return res;
    endfunction

    // absorb one accepted byte; a last byte queues the expected result
    function automatic void absorb_byte(shkh_pkg::t_in_item it);
        shkh_pkg::t_out_item res;
        if (pending_len < shkh_pkg::MAX_KEY_BYTES) begin
            pending_key[pending_len] = it.key_byte;
            pending_len++;
            run_hash = run_hash ^ ((run_hash << 5) + {24'd0, it.key_byte} + (run_hash >> 2));
        end else begin
            pending_long = 1'b1;
        end
        if (it.key_last) begin
            res = lookup_or_store(it.action, it.value);
            expected_results.push_back(res);
            status_cnt[res.status]++;
            run_hash = shkh_pkg::HASH_SEED;
            pending_len = 0;
            pending_long = 1'b0;
        end
    endfunction

    // one input transaction with a random lead-in gap
    task automatic send_byte(shkh_pkg::t_in_item it);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 5);
        repeat (gap) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        absorb_byte(it);
        byte_cnt++;
    endtask

    task automatic send_key(logic [7:0] kb[], logic act, logic [shkh_pkg::VAL_W-1:0] val);
        shkh_pkg::t_in_item it;
        foreach (kb[b]) begin
            it.action = (b == kb.size() - 1) ? act : logic'($urandom_range(0, 1));
            it.key_byte = kb[b];
            it.key_last = (b == kb.size() - 1);
            it.value = (b == kb.size() - 1) ? val : shkh_pkg::VAL_W'($urandom);
            send_byte(it);
        end
    endtask

    task automatic drain;
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        // a key byte with no result may still be in flight
        repeat (40) @(posedge i_clk);
    endtask

    // table_size is only written when nothing is in flight
    task automatic write_size(logic [shkh_pkg::CFG_W-1:0] sz);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= sz;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        size_reg = sz;
    endtask

    // result side: check each accepted transaction, then draw the next stall
    int stall_left = 0;
    always @(posedge i_clk) begin
        shkh_pkg::t_out_item want;
        int                  nxt;
        nxt = stall_left;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result status=%0d value_out=%0d", o_out.status,
                       o_out.value_out);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                if (o_out.status !== want.status) begin
                    $error("status expected %0d actual %0d", want.status, o_out.status);
                    mismatches++;
                end
                if (o_out.value_out !== want.value_out) begin
                    $error("value_out expected %0d actual %0d", want.value_out,
                           o_out.value_out);
                    mismatches++;
                end
            end
            nxt = calm ? 0 : $urandom_range(0, 5);
        end
        if (nxt > 0) begin
            i_out_stall <= 1'b1;
            stall_left <= nxt - 1;
        end else begin
            i_out_stall <= 1'b0;
            stall_left <= 0;
        end
    end

    // fixed-content directed keys
    task automatic test_basic_ops;
        logic [7:0] k_a[] = '{8'h61, 8'h62};
        logic [7:0] k_z[] = '{8'h00};
        logic [7:0] k_f[] = '{8'hFF, 8'hFF, 8'hFF};
        logic [7:0] k_zz[] = '{8'h00, 8'h00};
        send_key(k_a, shkh_pkg::ACT_GET, 16'h0000);     // get on empty table
        send_key(k_a, shkh_pkg::ACT_ADD, 16'hFFFF);     // insert
        send_key(k_a, shkh_pkg::ACT_GET, 16'h1234);     // found
        send_key(k_a, shkh_pkg::ACT_ADD, 16'h0000);     // update
        send_key(k_a, shkh_pkg::ACT_GET, 16'h0000);
        send_key(k_z, shkh_pkg::ACT_ADD, 16'h5A5A);     // zero byte is an ordinary byte
        send_key(k_zz, shkh_pkg::ACT_GET, 16'h0000);    // prefix relation does not match
        send_key(k_zz, shkh_pkg::ACT_ADD, 16'hA5A5);
        send_key(k_f, shkh_pkg::ACT_ADD, 16'h8001);
        send_key(k_f, shkh_pkg::ACT_GET, 16'h0000);
        send_key(k_z, shkh_pkg::ACT_GET, 16'h0000);
    endtask

    task automatic test_key_length;
        logic [7:0] kmax[] = new[shkh_pkg::MAX_KEY_BYTES];
        logic [7:0] klong[] = new[shkh_pkg::MAX_KEY_BYTES + 1];
        foreach (kmax[b]) kmax[b] = 8'(b * 7);
        foreach (klong[b]) klong[b] = 8'(b * 7);
        send_key(kmax, shkh_pkg::ACT_ADD, 16'h7777);    // longest allowed key
        send_key(kmax, shkh_pkg::ACT_GET, 16'h0000);
        send_key(klong, shkh_pkg::ACT_ADD, 16'h1111);   // one byte too many
        send_key(klong, shkh_pkg::ACT_GET, 16'h0000);
        send_key(kmax, shkh_pkg::ACT_GET, 16'h0000);    // state recovered after overflow
    endtask

    task automatic test_tiny_table;
        logic [7:0] k1[] = '{8'h31};
        logic [7:0] k2[] = '{8'h32};
        write_size(9'd1);
        send_key(k1, shkh_pkg::ACT_ADD, 16'h0101);      // the only slot is free: stored
        send_key(k2, shkh_pkg::ACT_ADD, 16'h0202);
        send_key(k2, shkh_pkg::ACT_GET, 16'h0000);
        write_size(9'd0);                               // acts as one slot
        send_key(k2, shkh_pkg::ACT_GET, 16'h0000);
        send_key(k1, shkh_pkg::ACT_GET, 16'h0000);
        write_size(9'd511);                             // clamps to the full depth
        send_key(k2, shkh_pkg::ACT_ADD, 16'h0303);
        send_key(k2, shkh_pkg::ACT_GET, 16'h0000);
    endtask

    // random keys from a reused pool so updates, hits and full tables all occur
    task automatic test_random_phase(logic [shkh_pkg::CFG_W-1:0] sz, int n_keys, bit quiet);
        logic [7:0] pool [16][];
        logic [7:0] kb[];
        int         len;
        int         pick;
        write_size(sz);
        calm = quiet;
        foreach (pool[p]) begin
            len = ($urandom_range(0, 9) == 0) ?
                  $urandom_range(9, shkh_pkg::MAX_KEY_BYTES + 3) : $urandom_range(1, 4);
            pool[p] = new[len];
            foreach (pool[p][b]) pool[p][b] = 8'($urandom);
        end
        for (int k = 0; k < n_keys; k++) begin
            if ($urandom_range(0, 5) == 0) begin
                kb = new[$urandom_range(1, 5)];
                foreach (kb[b]) kb[b] = 8'($urandom);
            end else begin
                pick = $urandom_range(0, 15);
                kb = pool[pick];
            end
            send_key(kb, logic'($urandom_range(0, 1)), shkh_pkg::VAL_W'($urandom));
        end
        calm = 1'b0;
    endtask

    initial begin
        foreach (used_mark[s]) used_mark[s] = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_basic_ops();
        test_key_length();
        test_tiny_table();
        test_random_phase(9'd256, 28, 1'b0);
        test_random_phase(9'd7, 28, 1'b0);
        test_random_phase(9'd2, 18, 1'b1);
        test_random_phase(9'd16, 28, 1'b0);
        test_random_phase(9'd3, 18, 1'b0);
        test_random_phase(9'd170, 24, 1'b1);
        test_random_phase(9'd85, 24, 1'b0);
        drain();
        $display("sent %0d key bytes; results stored=%0d found=%0d notfound=%0d",
                 byte_cnt, status_cnt[shkh_pkg::ST_STORED], status_cnt[shkh_pkg::ST_FOUND],
                 status_cnt[shkh_pkg::ST_NOTFOUND]);
        $display("nospace=%0d toolong=%0d over sizes 0 to 511",
                 status_cnt[shkh_pkg::ST_NOSPACE], status_cnt[shkh_pkg::ST_TOOLONG]);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // watchdog
    initial begin
        #20ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
